// ----- design/bsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants for the 24-bit BMP stream parser.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int HEADER_BYTES = 54;
    localparam int HDR_IDX_W    = 6;
    localparam int WIDTH_OFS    = 18;
    localparam int HEIGHT_OFS   = 22;
    localparam int FIELD_BYTES  = 4;

    localparam int COORD_W      = 12;
    localparam int DIM_OUT_W    = 13;
    localparam int COLOR_W      = 8;

    // Word classes handed from the front end to the back end
    typedef enum logic [2:0] {
        CLS_START,      // start of file, header byte 0
        CLS_WIDTH,      // one byte of the width field
        CLS_HEIGHT,     // one byte of the height field
        CLS_HDR_LAST,   // final header byte, size check
        CLS_BODY        // byte after the header
    } item_cls_t;

    typedef struct packed {
        item_cls_t          cls;
        logic [1:0]         lane;   // byte lane within width/height field
        logic [COLOR_W-1:0] data;
    } q_item_t;

endpackage

// ----- design/bmp24_stream_parser.sv -----
// ----------------------------------------------------------------------------
// bmp24_stream_parser
// Streaming 24-bit BMP decoder: one file byte per word in, one pixel out.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid/in_ready    data_byte, start_of_file
//  out      out_valid/out_ready  pixel_row, pixel_column, red, green, blue,
//                                last_pixel, image_width, image_height,
//                                size_error
//
//  One byte per cycle sustained while out_ready stays high; a pixel result
//  leaves one register stage after its red byte reaches the back end.
//  The front end classifies bytes; a two-entry queue separates it from the
//  back end, so input is taken while a result waits on out_ready.
//  Async reset (rst_n low) returns both ends to idle and empties the queue.
//  An out stall backs up the queue; in_ready drops once it holds two words.
//
module bmp24_stream_parser #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bsp_pkg::COLOR_W-1:0]     data_byte,
    input  logic                            start_of_file,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bsp_pkg::COORD_W-1:0]     pixel_row,
    output logic [bsp_pkg::COORD_W-1:0]     pixel_column,
    output logic [bsp_pkg::COLOR_W-1:0]     red,
    output logic [bsp_pkg::COLOR_W-1:0]     green,
    output logic [bsp_pkg::COLOR_W-1:0]     blue,
    output logic                            last_pixel,
    output logic [bsp_pkg::DIM_OUT_W-1:0]   image_width,
    output logic [bsp_pkg::DIM_OUT_W-1:0]   image_height,
    output logic                            size_error
);

    // Front-to-queue and queue-to-back words
    bsp_pkg::q_item_t  push_item;
    bsp_pkg::q_item_t  head_item;
    logic              q_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    // Header byte counting and classification; drops bytes that carry nothing
    bsp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    bsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    // Size check, pixel walk with row padding, result register
    bsp_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_pixel   (last_pixel),
        .image_width  (image_width),
        .image_height (image_height),
        .size_error   (size_error)
    );

endmodule

// ----- design/bsp_front.sv -----
// ----------------------------------------------------------------------------
// bsp_front
// Accepts input words, tracks the header position and classifies each word.
// ----------------------------------------------------------------------------
module bsp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bsp_pkg::COLOR_W-1:0]   data_byte,
    input  logic                          start_of_file,
    input  logic                          q_full,
    output logic                          q_push,
    output bsp_pkg::q_item_t              q_item
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_HEADER,
        F_BODY
    } front_state_t;

    front_state_t                       state_reg, state_next;
    logic [bsp_pkg::HDR_IDX_W-1:0]      idx_reg, idx_next;
    logic [bsp_pkg::HDR_IDX_W-1:0]      w_off;
    logic [bsp_pkg::HDR_IDX_W-1:0]      h_off;
    logic                               accept;
    logic                               in_width;
    logic                               in_height;
    logic                               is_last;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign w_off     = idx_reg - bsp_pkg::HDR_IDX_W'(bsp_pkg::WIDTH_OFS);
    assign h_off     = idx_reg - bsp_pkg::HDR_IDX_W'(bsp_pkg::HEIGHT_OFS);
    assign in_width  = (idx_reg >= bsp_pkg::HDR_IDX_W'(bsp_pkg::WIDTH_OFS)) &&
                       (w_off < bsp_pkg::HDR_IDX_W'(bsp_pkg::FIELD_BYTES));
    assign in_height = (idx_reg >= bsp_pkg::HDR_IDX_W'(bsp_pkg::HEIGHT_OFS)) &&
                       (h_off < bsp_pkg::HDR_IDX_W'(bsp_pkg::FIELD_BYTES));
    assign is_last   = (idx_reg == bsp_pkg::HDR_IDX_W'(bsp_pkg::HEADER_BYTES - 1));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        q_push      = 1'b0;
        q_item.cls  = bsp_pkg::CLS_BODY;
        q_item.lane = 2'd0;
        q_item.data = data_byte;
        if (accept)
        begin
            priority if (start_of_file)
            begin
                q_push     = 1'b1;
                q_item.cls = bsp_pkg::CLS_START;
                state_next = F_HEADER;
                idx_next   = bsp_pkg::HDR_IDX_W'(1);
            end
            else if (state_reg == F_HEADER)
            begin
                idx_next = idx_reg + bsp_pkg::HDR_IDX_W'(1);
                priority if (in_width)
                begin
                    q_push      = 1'b1;
                    q_item.cls  = bsp_pkg::CLS_WIDTH;
                    q_item.lane = w_off[1:0];
                end
                else if (in_height)
                begin
                    q_push      = 1'b1;
                    q_item.cls  = bsp_pkg::CLS_HEIGHT;
                    q_item.lane = h_off[1:0];
                end
                else if (is_last)
                begin
                    q_push     = 1'b1;
                    q_item.cls = bsp_pkg::CLS_HDR_LAST;
                    state_next = F_BODY;
                end
                else
                begin
                    q_push = 1'b0;      // header byte with no meaning here
                end
            end
            else if (state_reg == F_BODY)
            begin
                q_push = 1'b1;
            end
            else
            begin
                q_push = 1'b0;          // no start seen yet
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- design/bsp_queue.sv -----
// ----------------------------------------------------------------------------
// bsp_queue
// Two-entry queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module bsp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bsp_pkg::q_item_t   push_item,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output bsp_pkg::q_item_t   head
);

    bsp_pkg::q_item_t  mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/bsp_back.sv -----
// ----------------------------------------------------------------------------
// bsp_back
// Collects size fields, checks them, walks pixels and drives the result.
// ----------------------------------------------------------------------------
module bsp_back #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  bsp_pkg::q_item_t                q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bsp_pkg::COORD_W-1:0]     pixel_row,
    output logic [bsp_pkg::COORD_W-1:0]     pixel_column,
    output logic [bsp_pkg::COLOR_W-1:0]     red,
    output logic [bsp_pkg::COLOR_W-1:0]     green,
    output logic [bsp_pkg::COLOR_W-1:0]     blue,
    output logic                            last_pixel,
    output logic [bsp_pkg::DIM_OUT_W-1:0]   image_width,
    output logic [bsp_pkg::DIM_OUT_W-1:0]   image_height,
    output logic                            size_error
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_HEADER,
        B_PIXELS,
        B_DONE
    } back_state_t;

    back_state_t                    state_reg, state_next;
    logic [31:0]                    width_word_reg, width_word_next;
    logic [31:0]                    height_word_reg, height_word_next;
    logic                           bottom_up_reg, bottom_up_next;
    logic [DIM_W-1:0]               width_dim_reg, width_dim_next;
    logic [DIM_W-1:0]               height_dim_reg, height_dim_next;
    logic [DIM_W-1:0]               w_m1_reg, w_m1_next;
    logic [DIM_W-1:0]               h_m1_reg, h_m1_next;
    logic [DIM_W-1:0]               row_reg, row_next;
    logic [DIM_W-1:0]               col_reg, col_next;
    logic [1:0]                     triple_reg, triple_next;
    logic [1:0]                     pad_reg, pad_next;
    logic [bsp_pkg::COLOR_W-1:0]    blue_hold_reg, blue_hold_next;
    logic [bsp_pkg::COLOR_W-1:0]    green_hold_reg, green_hold_next;

    logic                           out_valid_reg, out_valid_next;
    logic [bsp_pkg::COORD_W-1:0]    row_out_reg, col_out_reg;
    logic [bsp_pkg::COLOR_W-1:0]    red_reg, green_reg, blue_reg;
    logic                           last_reg;
    logic [bsp_pkg::DIM_OUT_W-1:0]  width_out_reg, height_out_reg;
    logic                           err_reg;

    logic                           emit;
    logic                           emit_err;
    logic                           pix_last;
    logic [31:0]                    h_mag32;
    logic                           size_bad;
    logic [DIM_W-1:0]               row_val;
    logic [31:0]                    row32, col32, wd32, hd32;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    // Height magnitude and size check for the final header byte
    assign h_mag32  = height_word_reg[31] ? (~height_word_reg + 32'd1) : height_word_reg;
    assign size_bad = width_word_reg[31] || (width_word_reg == 32'd0) ||
                      (width_word_reg > 32'(MAX_DIM)) ||
                      (h_mag32 == 32'd0) || (h_mag32 > 32'(MAX_DIM));

    assign row_val  = bottom_up_reg ? (h_m1_reg - row_reg) : row_reg;
    assign pix_last = (row_reg == h_m1_reg) && (col_reg == w_m1_reg);
    assign row32    = 32'(row_val);
    assign col32    = 32'(col_reg);
    assign wd32     = 32'(width_dim_reg);
    assign hd32     = 32'(height_dim_reg);

    always_comb
    begin
        state_next       = state_reg;
        width_word_next  = width_word_reg;
        height_word_next = height_word_reg;
        bottom_up_next   = bottom_up_reg;
        width_dim_next   = width_dim_reg;
        height_dim_next  = height_dim_reg;
        w_m1_next        = w_m1_reg;
        h_m1_next        = h_m1_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        triple_next      = triple_reg;
        pad_next         = pad_reg;
        blue_hold_next   = blue_hold_reg;
        green_hold_next  = green_hold_reg;
        emit             = 1'b0;
        emit_err         = 1'b0;

        if (q_pop)
        begin
            unique case (q_item.cls)
                bsp_pkg::CLS_START:
                begin
                    state_next       = B_HEADER;
                    width_word_next  = '0;
                    height_word_next = '0;
                    bottom_up_next   = 1'b1;
                    blue_hold_next   = '0;
                    green_hold_next  = '0;
                    row_next         = '0;
                    col_next         = '0;
                    triple_next      = 2'd0;
                    pad_next         = 2'd0;
                end
                bsp_pkg::CLS_WIDTH:
                begin
                    width_word_next[{q_item.lane, 3'b000} +: 8] = q_item.data;
                end
                bsp_pkg::CLS_HEIGHT:
                begin
                    height_word_next[{q_item.lane, 3'b000} +: 8] = q_item.data;
                end
                bsp_pkg::CLS_HDR_LAST:
                begin
                    bottom_up_next = !height_word_reg[31];
                    if (size_bad)
                    begin
                        state_next = B_DONE;
                        emit       = 1'b1;
                        emit_err   = 1'b1;
                    end
                    else
                    begin
                        state_next      = B_PIXELS;
                        width_dim_next  = width_word_reg[DIM_W-1:0];
                        height_dim_next = h_mag32[DIM_W-1:0];
                        w_m1_next       = width_word_reg[DIM_W-1:0] - DIM_W'(1);
                        h_m1_next       = h_mag32[DIM_W-1:0] - DIM_W'(1);
                        row_next        = '0;
                        col_next        = '0;
                        triple_next     = 2'd0;
                        pad_next        = 2'd0;
                    end
                end
                bsp_pkg::CLS_BODY:
                begin
                    if (state_reg == B_PIXELS)
                    begin
                        priority if (pad_reg != 2'd0)
                        begin
                            pad_next = pad_reg - 2'd1;
                            if (pad_reg == 2'd1)
                            begin
                                row_next = row_reg + DIM_W'(1);
                            end
                        end
                        else if (triple_reg == 2'd0)
                        begin
                            blue_hold_next = q_item.data;
                            triple_next    = 2'd1;
                        end
                        else if (triple_reg == 2'd1)
                        begin
                            green_hold_next = q_item.data;
                            triple_next     = 2'd2;
                        end
                        else
                        begin
                            triple_next = 2'd0;
                            emit        = 1'b1;
                            if (pix_last)
                            begin
                                state_next = B_DONE;
                            end
                            else if (col_reg == w_m1_reg)
                            begin
                                col_next = '0;
                                pad_next = wd32[1:0];
                                if (wd32[1:0] == 2'd0)
                                begin
                                    row_next = row_reg + DIM_W'(1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + DIM_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        out_valid_next = emit || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and the result register
    always_ff @(posedge clk)
    begin
        width_word_reg  <= width_word_next;
        height_word_reg <= height_word_next;
        bottom_up_reg   <= bottom_up_next;
        width_dim_reg   <= width_dim_next;
        height_dim_reg  <= height_dim_next;
        w_m1_reg        <= w_m1_next;
        h_m1_reg        <= h_m1_next;
        row_reg         <= row_next;
        col_reg         <= col_next;
        triple_reg      <= triple_next;
        pad_reg         <= pad_next;
        blue_hold_reg   <= blue_hold_next;
        green_hold_reg  <= green_hold_next;
        if (emit)
        begin
            if (emit_err)
            begin
                row_out_reg    <= '0;
                col_out_reg    <= '0;
                red_reg        <= '0;
                green_reg      <= '0;
                blue_reg       <= '0;
                last_reg       <= 1'b0;
                width_out_reg  <= '0;
                height_out_reg <= '0;
                err_reg        <= 1'b1;
            end
            else
            begin
                row_out_reg    <= row32[bsp_pkg::COORD_W-1:0];
                col_out_reg    <= col32[bsp_pkg::COORD_W-1:0];
                red_reg        <= q_item.data;
                green_reg      <= green_hold_reg;
                blue_reg       <= blue_hold_reg;
                last_reg       <= pix_last;
                width_out_reg  <= wd32[bsp_pkg::DIM_OUT_W-1:0];
                height_out_reg <= hd32[bsp_pkg::DIM_OUT_W-1:0];
                err_reg        <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_row    = row_out_reg;
    assign pixel_column = col_out_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign last_pixel   = last_reg;
    assign image_width  = width_out_reg;
    assign image_height = height_out_reg;
    assign size_error   = err_reg;

endmodule

// ----- design/bsp_checker.sv -----
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks on the parser's results, bound to the top level.
// ----------------------------------------------------------------------------
module bsp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [bsp_pkg::COORD_W-1:0]     pixel_row,
    input  logic [bsp_pkg::COORD_W-1:0]     pixel_column,
    input  logic [bsp_pkg::COLOR_W-1:0]     red,
    input  logic [bsp_pkg::COLOR_W-1:0]     green,
    input  logic [bsp_pkg::COLOR_W-1:0]     blue,
    input  logic                            last_pixel,
    input  logic [bsp_pkg::DIM_OUT_W-1:0]   image_width,
    input  logic [bsp_pkg::DIM_OUT_W-1:0]   image_height,
    input  logic                            size_error
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_row) &&
        $stable(pixel_column) && $stable(red) && $stable(green) &&
        $stable(blue) && $stable(last_pixel) && $stable(size_error))
        else $error("result changed while stalled");

    // Size error result carries no last flag, size or coordinates
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && size_error |-> !last_pixel && image_width == '0 &&
        image_height == '0 && pixel_row == '0 && pixel_column == '0)
        else $error("size error result not cleared");

    // Pixel coordinates stay inside the image
    a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !size_error |-> ({1'b0, pixel_row} < image_height) &&
        ({1'b0, pixel_column} < image_width))
        else $error("pixel outside image");

    // Last pixel sits in the final column
    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pixel |->
        ({1'b0, pixel_column} == image_width - 13'd1))
        else $error("last pixel not in final column");

endmodule

bind bmp24_stream_parser bsp_checker u_bsp_checker (.*);

// ----- bench/tb_bmp24_stream_parser.sv -----
// ----------------------------------------------------------------------------
// tb_bmp24_stream_parser
// Self-checking bench for the 24-bit BMP stream parser. Byte streams (well
// formed files, bad sizes, cut-off files, restarts, stray bytes) are pushed
// through the in channel; a cycle-free software copy of the parser predicts
// every pixel word, and a monitor compares each word taken on the out channel
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bmp24_stream_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM     = 4096;
    // Longest run of cycles with no word moving on either channel. The out
    // side idles at random 81% of cycles at worst; this leaves ample margin.
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    // Parser state as seen by the predictor
    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_HEADER,
        PARSE_PIXELS,
        PARSE_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [bsp_pkg::COORD_W-1:0]   row;
        logic [bsp_pkg::COORD_W-1:0]   column;
        logic [bsp_pkg::COLOR_W-1:0]   red;
        logic [bsp_pkg::COLOR_W-1:0]   green;
        logic [bsp_pkg::COLOR_W-1:0]   blue;
        logic                          last;
        logic [bsp_pkg::DIM_OUT_W-1:0] width;
        logic [bsp_pkg::DIM_OUT_W-1:0] height;
        logic                          size_err;
    } pixel_word_t;

    // ------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------
    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          in_valid      = 1'b0;
    logic                          in_ready;
    logic [bsp_pkg::COLOR_W-1:0]   data_byte     = '0;
    logic                          start_of_file = 1'b0;
    logic                          out_valid;
    logic                          out_ready     = 1'b0;
    logic [bsp_pkg::COORD_W-1:0]   pixel_row;
    logic [bsp_pkg::COORD_W-1:0]   pixel_column;
    logic [bsp_pkg::COLOR_W-1:0]   red;
    logic [bsp_pkg::COLOR_W-1:0]   green;
    logic [bsp_pkg::COLOR_W-1:0]   blue;
    logic                          last_pixel;
    logic [bsp_pkg::DIM_OUT_W-1:0] image_width;
    logic [bsp_pkg::DIM_OUT_W-1:0] image_height;
    logic                          size_error;

    bmp24_stream_parser #(.MAX_DIM(MAX_DIM)) u_top (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .data_byte,
        .start_of_file,
        .out_valid,
        .out_ready,
        .pixel_row,
        .pixel_column,
        .red,
        .green,
        .blue,
        .last_pixel,
        .image_width,
        .image_height,
        .size_error
    );

    initial forever #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    pixel_word_t pending_pixels[$];     // predicted words, oldest first
    int          error_count   = 0;
    int          parsed_bytes  = 0;     // bytes the parser actually consumes
    int          send_idle_pct = 0;     // chance per word of a sender gap
    int          recv_idle_pct = 0;     // chance per cycle of out_ready low

    // Predictor copy of the parser state
    parse_phase_t pp_phase    = PARSE_IDLE;
    logic [31:0]  hdr_pos     = '0;
    logic [31:0]  width_field = '0;
    logic [31:0]  height_field = '0;
    logic [31:0]  height_abs  = '0;
    logic         bottom_up   = 1'b1;
    logic [31:0]  row_cnt     = '0;
    logic [31:0]  col_cnt     = '0;
    logic [31:0]  triple_pos  = '0;
    logic [31:0]  pad_left    = '0;
    logic [7:0]   blue_seen   = '0;
    logic [7:0]   green_seen  = '0;

    // ------------------------------------------------------------------
    // Predictor: advance the parser by one accepted byte and queue the
    // pixel word (or size error word) it produces, if any.
    // ------------------------------------------------------------------
    task automatic track_byte(input logic [7:0] b, input logic sof);
        pixel_word_t px;
        logic [31:0] row_idx;
        logic        at_end;
        px = '0;
        // Stray bytes in idle/done do not count toward the stimulus budget
        if (sof || pp_phase == PARSE_HEADER || pp_phase == PARSE_PIXELS)
            parsed_bytes++;
        if (sof) begin
            // A start flag restarts from header byte 0 whatever the phase
            pp_phase     = PARSE_HEADER;
            hdr_pos      = '0;
            width_field  = '0;
            height_field = '0;
            height_abs   = '0;
            bottom_up    = 1'b1;
            blue_seen    = '0;
            green_seen   = '0;
            row_cnt      = '0;
            col_cnt      = '0;
            triple_pos   = '0;
            pad_left     = '0;
        end
        case (pp_phase)
            PARSE_HEADER: begin
                if (hdr_pos >= bsp_pkg::WIDTH_OFS &&
                    hdr_pos < bsp_pkg::WIDTH_OFS + bsp_pkg::FIELD_BYTES)
                    width_field |= 32'(b) << (8 * (hdr_pos - bsp_pkg::WIDTH_OFS));
                else if (hdr_pos >= bsp_pkg::HEIGHT_OFS &&
                         hdr_pos < bsp_pkg::HEIGHT_OFS + bsp_pkg::FIELD_BYTES)
                    height_field |= 32'(b) << (8 * (hdr_pos - bsp_pkg::HEIGHT_OFS));
                if (hdr_pos + 1 < bsp_pkg::HEADER_BYTES) begin
                    hdr_pos++;
                end
                else begin
                    // Last header byte: resolve row order and check sizes
                    if (height_field[31]) begin
                        height_abs = -height_field;
                        bottom_up  = 1'b0;
                    end
                    else begin
                        height_abs = height_field;
                        bottom_up  = 1'b1;
                    end
                    if (width_field[31] || width_field == 0 || width_field > MAX_DIM ||
                        height_abs == 0 || height_abs > MAX_DIM) begin
                        pp_phase    = PARSE_DONE;
                        px.size_err = 1'b1;
                        pending_pixels.insert(pending_pixels.size(), px);
                    end
                    else begin
                        pp_phase   = PARSE_PIXELS;
                        row_cnt    = '0;
                        col_cnt    = '0;
                        triple_pos = '0;
                        pad_left   = '0;
                    end
                end
            end
            PARSE_PIXELS: begin
                if (pad_left != 0) begin
                    // Row padding is dropped; row advances on its last byte
                    pad_left--;
                    if (pad_left == 0)
                        row_cnt++;
                end
                else if (triple_pos == 0) begin
                    blue_seen  = b;
                    triple_pos = 1;
                end
                else if (triple_pos == 1) begin
                    green_seen = b;
                    triple_pos = 2;
                end
                else begin
                    triple_pos = 0;
                    row_idx    = bottom_up ? (height_abs - 1 - row_cnt) : row_cnt;
                    at_end     = (row_cnt == height_abs - 1) && (col_cnt == width_field - 1);
                    px.row     = row_idx[bsp_pkg::COORD_W-1:0];
                    px.column  = col_cnt[bsp_pkg::COORD_W-1:0];
                    px.red     = b;
                    px.green   = green_seen;
                    px.blue    = blue_seen;
                    px.last    = at_end;
                    px.width   = width_field[bsp_pkg::DIM_OUT_W-1:0];
                    px.height  = height_abs[bsp_pkg::DIM_OUT_W-1:0];
                    pending_pixels.insert(pending_pixels.size(), px);
                    if (at_end) begin
                        // Padding of the final row and anything after it is ignored
                        pp_phase = PARSE_DONE;
                    end
                    else begin
                        col_cnt++;
                        if (col_cnt == width_field) begin
                            col_cnt  = '0;
                            pad_left = {30'd0, width_field[1:0]};
                            if (pad_left == 0)
                                row_cnt++;
                        end
                    end
                end
            end
            default: ;  // idle and done ignore unflagged bytes
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: one word per call. Random gaps go in front of the word;
    // valid is only raised once per step so back-to-back words stay high.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic sof);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_of_file <= sof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_byte(b, sof);
    endtask

    // First 'upto' bytes of a header; width and height land at their
    // offsets, every other header byte is random.
    task automatic send_header(input logic [31:0] w, input logic [31:0] h,
                               input int upto);
        logic [31:0] field;
        logic [7:0]  b;
        for (int i = 0; i < upto; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i >= bsp_pkg::WIDTH_OFS && i < bsp_pkg::WIDTH_OFS + bsp_pkg::FIELD_BYTES) begin
                field = w >> (8 * (i - bsp_pkg::WIDTH_OFS));
                b     = field[7:0];
            end
            else if (i >= bsp_pkg::HEIGHT_OFS &&
                     i < bsp_pkg::HEIGHT_OFS + bsp_pkg::FIELD_BYTES) begin
                field = h >> (8 * (i - bsp_pkg::HEIGHT_OFS));
                b     = field[7:0];
            end
            send_byte(b, i == 0);
        end
    endtask

    task automatic send_body(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Pixel area size of a valid image: rows padded to four bytes
    function automatic int image_bytes(input logic [31:0] w, input logic [31:0] h);
        logic [31:0] mag;
        mag = h[31] ? -h : h;
        return int'(((3 * w + 3) & ~32'd3) * mag);
    endfunction

    // Whole file plus 'extra' trailing bytes that must be ignored
    task automatic send_bmp(input logic [31:0] w, input logic [31:0] h, input int extra);
        send_header(w, h, bsp_pkg::HEADER_BYTES);
        send_body(image_bytes(w, h) + extra);
    endtask

    // ------------------------------------------------------------------
    // Monitor: compare each taken word with the oldest prediction, and
    // drive out_ready for the next cycle.
    // ------------------------------------------------------------------
    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk) begin : pixel_monitor
        pixel_word_t want;
        if (out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word, expected none, actual row=%0d col=%0d err=%0b",
                         $time, pixel_row, pixel_column, size_error);
            end
            else begin
                want = pending_pixels.pop_front();
                check_field("pixel_row",    want.row,      pixel_row);
                check_field("pixel_column", want.column,   pixel_column);
                check_field("red",          want.red,      red);
                check_field("green",        want.green,    green);
                check_field("blue",         want.blue,     blue);
                check_field("last_pixel",   want.last,     last_pixel);
                check_field("image_width",  want.width,    image_width);
                check_field("image_height", want.height,   image_height);
                check_field("size_error",   want.size_err, size_error);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: ends the run if no word moves on either side for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_bmp24_stream_parser: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Unflagged bytes straight after reset: parser stays idle, no output
    task automatic test_stray_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // Tiny images: both row orders, all four padding lengths, trailing bytes
    task automatic test_small_images();
        send_bmp(1, 1, 0);      // pad 1, single pixel is also the last
        send_bmp(2, -2, 0);     // top-down, pad 2
        send_bmp(3, 2, 0);      // bottom-up, pad 3
        send_bmp(4, -1, 3);     // no padding, trailing bytes dropped
    endtask

    // Each bad size gives one error word; following bytes are ignored
    task automatic test_size_errors();
        send_header(0, 1, bsp_pkg::HEADER_BYTES);                 send_body(1);
        send_header(MAX_DIM + 1, 1, bsp_pkg::HEADER_BYTES);       send_body(1);
        send_header(32'hFFFF_FFFF, 1, bsp_pkg::HEADER_BYTES);     send_body(1);
        send_header(1, 0, bsp_pkg::HEADER_BYTES);                 send_body(1);
        send_header(1, -(MAX_DIM + 1), bsp_pkg::HEADER_BYTES);    send_body(1);
        send_header(1, 32'h8000_0000, bsp_pkg::HEADER_BYTES);     send_body(1);
        // Largest legal sizes pass the check silently; next start cuts it off
        send_header(MAX_DIM, -MAX_DIM, bsp_pkg::HEADER_BYTES);    send_body(4);
    endtask

    // Start flag mid-header, on the last header byte, and mid-pixel
    task automatic test_restart();
        send_header(2, 2, 30);
        send_header(2, 2, bsp_pkg::HEADER_BYTES - 1);
        send_header(3, -2, bsp_pkg::HEADER_BYTES);
        send_body(7);           // ends after the blue byte of the third pixel
        send_bmp(2, 1, 0);
    endtask

    // Tallest bottom-up image starts at row 4095; cut short by the next start
    task automatic test_max_dims();
        send_header(1, MAX_DIM, bsp_pkg::HEADER_BYTES);
        send_body(12);
    endtask

    // Mostly well-formed small files with random content; the rest are
    // cut-off files, bad sizes, broken headers and loose bytes.
    task automatic test_random_files(input int budget);
        int          stop_at;
        int          kind;
        int          hm;
        logic [31:0] w;
        logic [31:0] h;
        stop_at = parsed_bytes + budget;
        while (parsed_bytes < stop_at) begin
            kind = $urandom_range(0, 99);
            w    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
            hm   = $urandom_range(1, 4);
            h    = $urandom_range(0, 1) ? -hm : hm;
            if (kind < 70) begin
                send_bmp(w, h, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
            end
            else if (kind < 80) begin
                // cut off; the next start flag restarts the parser
                send_header(w, h, bsp_pkg::HEADER_BYTES);
                send_body($urandom_range(0, image_bytes(w, h) - 1));
            end
            else if (kind < 90) begin
                case ($urandom_range(0, 4))
                    0: begin
                        w = $urandom();
                        h = $urandom();
                    end
                    1: w = $urandom_range(0, 1) ? 0 : MAX_DIM + $urandom_range(1, 4);
                    2: begin
                        case ($urandom_range(0, 2))
                            0: h = 0;
                            1: h = MAX_DIM + $urandom_range(1, 4);
                            default: h = -(MAX_DIM + $urandom_range(1, 4));
                        endcase
                    end
                    3: w = 32'h8000_0000 | $urandom();
                    default: h = 32'h8000_0000;
                endcase
                send_header(w, h, bsp_pkg::HEADER_BYTES);
                send_body($urandom_range(0, 4));
            end
            else if (kind < 95) begin
                send_header($urandom(), $urandom(),
                            $urandom_range(1, bsp_pkg::HEADER_BYTES - 1));
            end
            else begin
                for (int i = $urandom_range(1, 20); i > 0; i--)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : main
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles a little, receiver a lot: output backs up
        send_idle_pct = 36;
        recv_idle_pct = 81;
        test_stray_bytes();
        test_small_images();
        test_size_errors();
        test_restart();
        test_random_files(100);

        // Sender starves the parser, receiver mostly ready
        send_idle_pct = 81;
        recv_idle_pct = 36;
        test_random_files(100);

        // Full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_max_dims();
        test_random_files(100);

        in_valid <= 1'b0;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0) begin
            error_count += pending_pixels.size();
            $display("%0t: %0d expected words never arrived", $time, pending_pixels.size());
        end

        if (error_count == 0)
            $display("tb_bmp24_stream_parser: clean");
        else
            $display("tb_bmp24_stream_parser: errors");
        $finish;
    end

endmodule

// ----- bmp24_stream_parser.f -----
design/bsp_pkg.sv
design/bsp_front.sv
design/bsp_queue.sv
design/bsp_back.sv
design/bmp24_stream_parser.sv
design/bsp_checker.sv
bench/tb_bmp24_stream_parser.sv
